[src/buddy_allocator_core_assert.svh]
// Assertion macros used by the buddy allocator core.
`ifndef BUDDY_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BUD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BUD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BUD_ASSERT(lbl, clk, rstn, prop, msg)
`define BUD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[src/bud_pkg.sv]
// Types and constants of the buddy allocator.
`timescale 1ns / 1ps
package bud_pkg;
    localparam int LEVELS = 10;
    localparam int UNITS = 1 << LEVELS;
    localparam int UNIT_W = LEVELS;
    localparam int LINK_W = UNIT_W + 1;
    localparam int ORD_W = 4;
    localparam int KIND_W = 2;
    localparam int REQ_W = 15;
    localparam int STATUS_W = 2;
    localparam int HEAP_LEVELS_RESET = 10;

    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(UNITS);

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_USED = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ORD_W-1:0] order;
    } meta_t;

    typedef struct packed {
        logic init;
        logic [ORD_W-1:0] init_level;
        logic we;
        logic [ORD_W-1:0] order;
        logic [LINK_W-1:0] data;
    } head_ctl_t;
endpackage

[src/bud_req_if.sv]
// Request channel of the buddy allocator.
`timescale 1ns / 1ps
interface bud_req_if;
    logic valid;
    logic ready;
    logic func;
    logic [bud_pkg::REQ_W-1:0] request_bytes;
    logic [bud_pkg::UNIT_W-1:0] free_address;

    modport source (output valid, func, request_bytes, free_address, input ready);
    modport sink (input valid, func, request_bytes, free_address, output ready);
endinterface

[src/bud_rsp_if.sv]
// Response channel of the buddy allocator.
`timescale 1ns / 1ps
interface bud_rsp_if;
    logic valid;
    logic ready;
    logic [bud_pkg::UNIT_W-1:0] block_address;
    logic [bud_pkg::ORD_W-1:0] block_order;
    logic [bud_pkg::STATUS_W-1:0] status;

    modport source (output valid, block_address, block_order, status, input ready);
    modport sink (input valid, block_address, block_order, status, output ready);
endinterface

[src/buddy_allocator_core.sv]
`timescale 1ns / 1ps
// Binary buddy allocator over a heap of 2^heap_levels units of MIN_BLOCK_BYTES.
// req: func 0 allocates request_bytes, func 1 frees the block at free_address.
// rsp: one response per request with block_address, block_order and status
//   (0 ok, 1 out of memory, 2 request larger than heap, 3 bad free address).
// cfg_write_en/cfg_write_data set heap_levels and rebuild the heap as one block.
// One request is processed at a time; state sits in two 1024-entry RAMs
// (links and per-unit kind/order) plus a register file of list heads.
// An allocate takes one split step per halving of the block it pops; a
//   free takes a merge pass per level it merges, plus one walk step per list
//   entry passed to unlink a buddy; the links RAM read port sets the walk rate.
// req.ready rises again in the same cycle as the response is registered.
// After reset and after every heap_levels write a pass over all 1024 entries
//   clears the RAMs; req.ready stays low meanwhile.
// The response is held in an output register; a new request is taken while
//   it waits, and the next response waits until rsp.ready takes the old one.
module buddy_allocator_core #(
    parameter int MIN_BLOCK_BYTES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [bud_pkg::ORD_W-1:0]    cfg_write_data,
    bud_req_if.sink                      req,
    bud_rsp_if.source                    rsp
);
`include "buddy_allocator_core_assert.svh"

    localparam int UW = bud_pkg::UNIT_W;
    localparam int OW = bud_pkg::ORD_W;
    localparam int LW = bud_pkg::LINK_W;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_A_DEC   = 4'd2;
    localparam logic [3:0] S_A_FIND  = 4'd3;
    localparam logic [3:0] S_A_POPW  = 4'd4;
    localparam logic [3:0] S_A_SPLIT = 4'd5;
    localparam logic [3:0] S_F_RD    = 4'd6;
    localparam logic [3:0] S_F_CHK   = 4'd7;
    localparam logic [3:0] S_M_RD    = 4'd8;
    localparam logic [3:0] S_M_CHK   = 4'd9;
    localparam logic [3:0] S_U_HEAD  = 4'd10;
    localparam logic [3:0] S_U_WALK  = 4'd11;
    localparam logic [3:0] S_U_LINK  = 4'd12;
    localparam logic [3:0] S_M_ADV   = 4'd13;
    localparam logic [3:0] S_F_PUSH  = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [OW-1:0] hl_reg, hl_next;
    logic [UW-1:0] clr_cnt_reg, clr_cnt_next;
    logic out_valid_reg, out_valid_next;

    logic [bud_pkg::REQ_W-1:0] req_bytes_reg, req_bytes_next;
    logic [UW-1:0] faddr_reg, faddr_next;
    logic [OW-1:0] k_reg, k_next;
    logic fits_reg, fits_next;
    logic [OW-1:0] j_reg, j_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [UW-1:0] addr_reg, addr_next;
    logic [UW-1:0] buddy_reg, buddy_next;
    logic [UW-1:0] prev_reg, prev_next;
    logic [UW-1:0] res_addr_reg, res_addr_next;
    logic [OW-1:0] res_order_reg, res_order_next;
    logic [bud_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [UW-1:0] out_addr_reg, out_addr_next;
    logic [OW-1:0] out_order_reg, out_order_next;
    logic [bud_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic link_we, link_re;
    logic [UW-1:0] link_waddr, link_raddr;
    logic [LW-1:0] link_wdata, link_rdata;
    logic meta_we, meta_re;
    logic [UW-1:0] meta_waddr, meta_raddr;
    bud_pkg::meta_t meta_wdata, meta_rdata;

    bud_pkg::head_ctl_t hctl;
    logic [OW-1:0] head_rd_order;
    logic [LW-1:0] head_rd;
    logic find_ok;
    logic [OW-1:0] find_order;

    logic [OW-1:0] k_calc;
    logic fits_calc;
    logic [OW-1:0] cfg_sat;
    logic [OW-1:0] jm;

    bud_ram #(.WIDTH(LW), .DEPTH(bud_pkg::UNITS)) u_links (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
    );

    bud_ram #(.WIDTH($bits(bud_pkg::meta_t)), .DEPTH(bud_pkg::UNITS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
    );

    bud_heads u_heads (
        .clk(clk), .rst_n(rst_n), .ctl(hctl),
        .rd_order(head_rd_order), .rd_head(head_rd),
        .min_order(k_reg), .max_order(hl_reg),
        .found(find_ok), .found_order(find_order)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.block_order = out_order_reg;
    assign rsp.status = out_status_reg;

    assign cfg_sat = (int'(cfg_write_data) > bud_pkg::LEVELS) ? OW'(bud_pkg::LEVELS)
                                                             : cfg_write_data;
    assign jm = j_reg - OW'(1);

    // round the request up to the smallest order that covers it
    always_comb
    begin
        k_calc = '0;
        fits_calc = 1'b0;
        for (int i = bud_pkg::LEVELS; i >= 0; i--)
        begin
            if (i <= int'(hl_reg)
                && ({17'b0, req_bytes_reg} <= (32'(MIN_BLOCK_BYTES) << i)))
            begin
                k_calc = OW'(i);
                fits_calc = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hl_next = hl_reg;
        clr_cnt_next = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        req_bytes_next = req_bytes_reg;
        faddr_next = faddr_reg;
        k_next = k_reg;
        fits_next = fits_reg;
        j_next = j_reg;
        ord_next = ord_reg;
        addr_next = addr_reg;
        buddy_next = buddy_reg;
        prev_next = prev_reg;
        res_addr_next = res_addr_reg;
        res_order_next = res_order_reg;
        res_status_next = res_status_reg;
        out_addr_next = out_addr_reg;
        out_order_next = out_order_reg;
        out_status_next = out_status_reg;
        link_we = 1'b0;
        link_waddr = addr_reg;
        link_wdata = '0;
        link_re = 1'b0;
        link_raddr = addr_reg;
        meta_we = 1'b0;
        meta_waddr = addr_reg;
        meta_wdata = '0;
        meta_re = 1'b0;
        meta_raddr = faddr_reg;
        hctl = '0;
        head_rd_order = ord_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                link_we = 1'b1;
                link_waddr = clr_cnt_reg;
                link_wdata = bud_pkg::EMPTY_MARK;
                meta_we = 1'b1;
                meta_waddr = clr_cnt_reg;
                if (clr_cnt_reg == '0)
                begin
                    meta_wdata = '{kind: bud_pkg::KIND_FREE, order: hl_reg};
                end
                else
                begin
                    meta_wdata = '{kind: bud_pkg::KIND_NONE, order: '0};
                end
                clr_cnt_next = clr_cnt_reg + UW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_bytes_next = req.request_bytes;
                    faddr_next = req.free_address;
                    state_next = (req.func == bud_pkg::FUNC_FREE) ? S_F_RD : S_A_DEC;
                end
            end
            S_A_DEC:
            begin
                k_next = k_calc;
                fits_next = fits_calc;
                state_next = S_A_FIND;
            end
            S_A_FIND:
            begin
                head_rd_order = find_order;
                if (!fits_reg)
                begin
                    res_addr_next = '0;
                    res_order_next = '0;
                    res_status_next = bud_pkg::ST_TOO_BIG;
                    state_next = S_OUT;
                end
                else if (!find_ok)
                begin
                    res_addr_next = '0;
                    res_order_next = '0;
                    res_status_next = bud_pkg::ST_NO_MEM;
                    state_next = S_OUT;
                end
                else
                begin
                    // pop: fetch the successor of the head
                    j_next = find_order;
                    addr_next = head_rd[UW-1:0];
                    link_re = 1'b1;
                    link_raddr = head_rd[UW-1:0];
                    state_next = S_A_POPW;
                end
            end
            S_A_POPW:
            begin
                hctl.we = 1'b1;
                hctl.order = j_reg;
                hctl.data = link_rdata;
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                head_rd_order = jm;
                if (j_reg > k_reg)
                begin
                    // push the lower half, continue with the upper half
                    link_we = 1'b1;
                    link_waddr = addr_reg;
                    link_wdata = head_rd;
                    meta_we = 1'b1;
                    meta_waddr = addr_reg;
                    meta_wdata = '{kind: bud_pkg::KIND_FREE, order: jm};
                    hctl.we = 1'b1;
                    hctl.order = jm;
                    hctl.data = {1'b0, addr_reg};
                    addr_next = addr_reg + (UW'(1) << jm);
                    j_next = jm;
                end
                else
                begin
                    meta_we = 1'b1;
                    meta_waddr = addr_reg;
                    meta_wdata = '{kind: bud_pkg::KIND_USED, order: k_reg};
                    res_addr_next = addr_reg;
                    res_order_next = k_reg;
                    res_status_next = bud_pkg::ST_OK;
                    state_next = S_OUT;
                end
            end
            S_F_RD:
            begin
                if ((faddr_reg >> hl_reg) != '0)
                begin
                    res_addr_next = faddr_reg;
                    res_order_next = '0;
                    res_status_next = bud_pkg::ST_BAD_FREE;
                    state_next = S_OUT;
                end
                else
                begin
                    meta_re = 1'b1;
                    meta_raddr = faddr_reg;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (meta_rdata.kind != bud_pkg::KIND_USED)
                begin
                    res_addr_next = faddr_reg;
                    res_order_next = '0;
                    res_status_next = bud_pkg::ST_BAD_FREE;
                    state_next = S_OUT;
                end
                else
                begin
                    ord_next = (meta_rdata.order > hl_reg) ? hl_reg : meta_rdata.order;
                    meta_we = 1'b1;
                    meta_waddr = faddr_reg;
                    meta_wdata = '{kind: bud_pkg::KIND_NONE, order: meta_rdata.order};
                    addr_next = faddr_reg;
                    state_next = S_M_RD;
                end
            end
            S_M_RD:
            begin
                if (ord_reg >= hl_reg)
                begin
                    state_next = S_F_PUSH;
                end
                else
                begin
                    buddy_next = addr_reg ^ (UW'(1) << ord_reg);
                    meta_re = 1'b1;
                    meta_raddr = addr_reg ^ (UW'(1) << ord_reg);
                    state_next = S_M_CHK;
                end
            end
            S_M_CHK:
            begin
                if (meta_rdata.kind != bud_pkg::KIND_FREE || meta_rdata.order != ord_reg)
                begin
                    state_next = S_F_PUSH;
                end
                else if (head_rd == {1'b0, buddy_reg})
                begin
                    link_re = 1'b1;
                    link_raddr = buddy_reg;
                    state_next = S_U_HEAD;
                end
                else if (head_rd[UW])
                begin
                    state_next = S_M_ADV;
                end
                else
                begin
                    prev_next = head_rd[UW-1:0];
                    link_re = 1'b1;
                    link_raddr = head_rd[UW-1:0];
                    state_next = S_U_WALK;
                end
            end
            S_U_HEAD:
            begin
                hctl.we = 1'b1;
                hctl.order = ord_reg;
                hctl.data = link_rdata;
                state_next = S_M_ADV;
            end
            S_U_WALK:
            begin
                // advance one list entry per cycle until the buddy shows up or the list ends
                if (link_rdata[UW])
                begin
                    state_next = S_M_ADV;
                end
                else if (link_rdata[UW-1:0] == buddy_reg)
                begin
                    link_re = 1'b1;
                    link_raddr = buddy_reg;
                    state_next = S_U_LINK;
                end
                else
                begin
                    prev_next = link_rdata[UW-1:0];
                    link_re = 1'b1;
                    link_raddr = link_rdata[UW-1:0];
                end
            end
            S_U_LINK:
            begin
                link_we = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata;
                state_next = S_M_ADV;
            end
            S_M_ADV:
            begin
                meta_we = 1'b1;
                meta_waddr = buddy_reg;
                meta_wdata = '{kind: bud_pkg::KIND_NONE, order: ord_reg};
                if (buddy_reg < addr_reg)
                begin
                    addr_next = buddy_reg;
                end
                ord_next = ord_reg + OW'(1);
                state_next = S_M_RD;
            end
            S_F_PUSH:
            begin
                link_we = 1'b1;
                link_waddr = addr_reg;
                link_wdata = head_rd;
                hctl.we = 1'b1;
                hctl.order = ord_reg;
                hctl.data = {1'b0, addr_reg};
                meta_we = 1'b1;
                meta_waddr = addr_reg;
                meta_wdata = '{kind: bud_pkg::KIND_FREE, order: ord_reg};
                res_addr_next = addr_reg;
                res_order_next = ord_reg;
                res_status_next = bud_pkg::ST_OK;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next = res_addr_reg;
                    out_order_next = res_order_reg;
                    out_status_next = res_status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a heap_levels write rebuilds the heap
        if (cfg_write_en)
        begin
            hl_next = cfg_sat;
            hctl.init = 1'b1;
            hctl.init_level = cfg_sat;
            clr_cnt_next = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hl_reg <= OW'(bud_pkg::HEAP_LEVELS_RESET);
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hl_reg <= hl_next;
            clr_cnt_reg <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_bytes_reg <= req_bytes_next;
        faddr_reg <= faddr_next;
        k_reg <= k_next;
        fits_reg <= fits_next;
        j_reg <= j_next;
        ord_reg <= ord_next;
        addr_reg <= addr_next;
        buddy_reg <= buddy_next;
        prev_reg <= prev_next;
        res_addr_reg <= res_addr_next;
        res_order_reg <= res_order_next;
        res_status_reg <= res_status_next;
        out_addr_reg <= out_addr_next;
        out_order_reg <= out_order_next;
        out_status_reg <= out_status_next;
    end

    `BUD_ASSERT(a_split_above_target, clk, rst_n, (state_reg == S_A_SPLIT) |-> (j_reg >= k_reg), "split order below target")
    `BUD_ASSERT(a_rsp_from_out, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_OUT), "response raised outside output state")
    `BUD_ASSERT_NEVER(a_walk_prev_not_buddy, clk, rst_n, (state_reg == S_U_WALK) && (prev_reg == buddy_reg), "list walk passed the buddy")
    `BUD_ASSERT(a_merge_in_heap, clk, rst_n, (state_reg == S_M_CHK) |-> (ord_reg < hl_reg), "merge beyond heap order")
endmodule

[src/bud_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[src/bud_heads.sv]
// Free-list head registers with the search for the smallest usable order.
`timescale 1ns / 1ps
module bud_heads (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bud_pkg::head_ctl_t          ctl,
    input  logic [bud_pkg::ORD_W-1:0]   rd_order,
    output logic [bud_pkg::LINK_W-1:0]  rd_head,
    input  logic [bud_pkg::ORD_W-1:0]   min_order,
    input  logic [bud_pkg::ORD_W-1:0]   max_order,
    output logic                        found,
    output logic [bud_pkg::ORD_W-1:0]   found_order
);
    logic [bud_pkg::LINK_W-1:0] head_reg [bud_pkg::LEVELS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= bud_pkg::LEVELS; i++)
            begin
                head_reg[i] <= (i == bud_pkg::HEAP_LEVELS_RESET) ? '0 : bud_pkg::EMPTY_MARK;
            end
        end
        else if (ctl.init)
        begin
            for (int i = 0; i <= bud_pkg::LEVELS; i++)
            begin
                head_reg[i] <= (i == int'(ctl.init_level)) ? '0 : bud_pkg::EMPTY_MARK;
            end
        end
        else if (ctl.we)
        begin
            head_reg[ctl.order] <= ctl.data;
        end
    end

    assign rd_head = head_reg[rd_order];

    // lowest non-empty order inside [min_order, max_order]
    always_comb
    begin
        found = 1'b0;
        found_order = '0;
        for (int i = bud_pkg::LEVELS; i >= 0; i--)
        begin
            if (!head_reg[i][bud_pkg::UNIT_W] && i >= int'(min_order)
                && i <= int'(max_order))
            begin
                found = 1'b1;
                found_order = bud_pkg::ORD_W'(i);
            end
        end
    end
endmodule
